@@ hw/rtl/rrol_pkg.sv @@
// ----------------------------------------------------------------------------
// rrol_pkg: shared types and constants of the record ring offset lookup
// Item and result layouts, the lookup probe passed between cells, and the
// controller state type.
// ----------------------------------------------------------------------------
package rrol_pkg;

   localparam int HANDLE_BITS = 32;
   localparam int SIZE_BITS   = 16;
   localparam int OFS_BITS    = 20;
   localparam int SLOT_BITS   = 4;
   localparam int HELD_BITS   = 20;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_FIND = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [HANDLE_BITS-1:0] entry_handle;
      logic [SIZE_BITS-1:0]   entry_size;
      logic [OFS_BITS-1:0]    byte_offset;
   } req_type;

   typedef struct packed {
      logic                   evicted_valid;
      logic [HANDLE_BITS-1:0] evicted_handle;
      logic                   found;
      logic [SLOT_BITS-1:0]   slot_index;
      logic [HANDLE_BITS-1:0] found_handle;
      logic [SIZE_BITS-1:0]   byte_in_entry;
      logic [HELD_BITS-1:0]   bytes_held;
   } rsp_type;

   // Lookup probe: remaining byte offset walking from cell to cell
   typedef struct packed {
      logic                valid;
      logic [OFS_BITS-1:0] rem;
   } probe_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

@@ hw/rtl/rrol_cell.sv @@
// ----------------------------------------------------------------------------
// rrol_cell: one ring slot
// Holds a record's handle and length. A lookup probe parked here either hits
// (remaining offset below the length) or moves on with the length taken off.
// ----------------------------------------------------------------------------
module rrol_cell #(
   parameter int LEN_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [rrol_pkg::HANDLE_BITS-1:0]  wr_handle,
   input  logic [LEN_BITS-1:0]               wr_len,
   input  rrol_pkg::probe_type               inject,
   input  rrol_pkg::probe_type               upstream,
   output rrol_pkg::probe_type               downstream,
   output logic                              hit,
   output logic [rrol_pkg::OFS_BITS-1:0]     hit_rem,
   output logic [rrol_pkg::HANDLE_BITS-1:0]  handle,
   output logic [LEN_BITS-1:0]               len
);

   localparam int W = (LEN_BITS > rrol_pkg::OFS_BITS) ? LEN_BITS : rrol_pkg::OFS_BITS;

   rrol_pkg::probe_type              probe_ff, probe_in;
   logic [rrol_pkg::HANDLE_BITS-1:0] handle_ff;
   logic [LEN_BITS-1:0]              len_ff;
   logic [W-1:0]                     rem_w, len_w;

   always_comb begin
      probe_in.valid = inject.valid | upstream.valid;
      probe_in.rem   = inject.valid ? inject.rem : upstream.rem;
   end

   always_comb begin
      rem_w           = W'(probe_ff.rem);
      len_w           = W'(len_ff);
      hit             = probe_ff.valid && (rem_w < len_w);
      downstream.valid = probe_ff.valid && !hit;
      downstream.rem  = rrol_pkg::OFS_BITS'(rem_w - len_w);
   end

   assign hit_rem = probe_ff.rem;
   assign handle  = handle_ff;
   assign len     = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
         len_ff   <= '0;
      end else begin
         probe_ff <= probe_in;
         if (wr_en) begin
            len_ff <= wr_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         handle_ff <= wr_handle;
      end
   end

endmodule

@@ hw/rtl/record_ring_offset_lookup.sv @@
// ----------------------------------------------------------------------------
// record_ring_offset_lookup: ring of records with byte offset lookup
// Holds up to DEPTH records (handle, length) and maps a byte offset into the
// oldest-first concatenation of records back to its slot and handle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the item transfers at a rising edge with
//   start high and busy low. Every item yields one result, shown on rsp_item
//   for exactly one cycle with rsp_valid high; the receiver cannot stall it.
//   An add writes the record at the write position, evicting the oldest one
//   when the ring is full, and its result shows in the cycle after the
//   transfer; busy stays low, so adds may be issued every cycle.
//   A lookup whose offset is not below the bytes held answers in the cycle
//   after the transfer. Otherwise a probe is placed in the oldest slot's cell
//   and moves one cell per cycle along the ring of cells; busy stays high
//   while it walks, from the oldest slot up to the one holding the offset,
//   and the result shows in the cycle after the last walk cycle.
//   Reset empties the ring, clears all lengths and the byte total, and drops
//   any lookup in flight; handles are not cleared.
// ----------------------------------------------------------------------------
module record_ring_offset_lookup #(
   parameter int DEPTH    = 16,
   parameter int LEN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrol_pkg::req_type req_item,
   output logic              rsp_valid,
   output rrol_pkg::rsp_type rsp_item
);

   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TOT_RAW   = LEN_BITS + PTR_BITS + 1;
   localparam int TOT_BITS  = (TOT_RAW > rrol_pkg::OFS_BITS + 1) ? TOT_RAW
                                                                  : rrol_pkg::OFS_BITS + 1;
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   rrol_pkg::state_type         state_ff, state_in;
   logic [PTR_BITS-1:0]         wr_pos_ff, wr_pos_in, rd_pos_ff, rd_pos_in;
   logic                        full_ff, full_in;
   logic [TOT_BITS-1:0]         total_ff, total_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rrol_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        accept, do_add, do_find, in_range;
   logic [LEN_BITS-1:0]         new_len;
   logic [PTR_BITS-1:0]         wr_pos_next;

   rrol_pkg::probe_type         inject    [DEPTH];
   rrol_pkg::probe_type         fwd       [DEPTH];
   logic                        wr_sel    [DEPTH];
   logic [DEPTH-1:0]            hit_vec;
   logic [DEPTH-1:0]            probe_vec;
   logic [rrol_pkg::OFS_BITS-1:0]    cell_rem    [DEPTH];
   logic [rrol_pkg::HANDLE_BITS-1:0] cell_handle [DEPTH];
   logic [LEN_BITS-1:0]              cell_len    [DEPTH];

   logic [rrol_pkg::HANDLE_BITS-1:0] old_handle, hit_handle;
   logic [LEN_BITS-1:0]              old_len;
   logic [rrol_pkg::OFS_BITS-1:0]    hit_rem;
   logic [PTR_BITS-1:0]              hit_slot;
   logic                             any_hit;

   assign accept   = start && !busy;
   assign do_add   = accept && (req_item.mode == rrol_pkg::MODE_ADD);
   assign do_find  = accept && (req_item.mode == rrol_pkg::MODE_FIND);
   assign in_range = TOT_BITS'(req_item.byte_offset) < total_ff;
   assign new_len  = LEN_BITS'({16'b0, req_item.entry_size});
   assign wr_pos_next = (wr_pos_ff == LAST_PTR) ? '0 : wr_pos_ff + 1'b1;

   // ---- row of cells ----
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
         wr_sel[i]       = do_add && (wr_pos_ff == PTR_BITS'(i));
         inject[i].valid = do_find && in_range && (rd_pos_ff == PTR_BITS'(i));
         inject[i].rem   = req_item.byte_offset;
         probe_vec[i]    = fwd[i].valid;
      end

      rrol_cell #(
         .LEN_BITS (LEN_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_sel[i]),
         .wr_handle  (req_item.entry_handle),
         .wr_len     (new_len),
         .inject     (inject[i]),
         .upstream   (fwd[(i + DEPTH - 1) % DEPTH]),
         .downstream (fwd[i]),
         .hit        (hit_vec[i]),
         .hit_rem    (cell_rem[i]),
         .handle     (cell_handle[i]),
         .len        (cell_len[i])
      );
   end

   // Collect the overwritten record and the hitting cell (both one-hot)
   always_comb begin
      old_handle = '0;
      old_len    = '0;
      hit_handle = '0;
      hit_rem    = '0;
      hit_slot   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (wr_pos_ff == PTR_BITS'(i)) begin
            old_handle = cell_handle[i];
            old_len    = cell_len[i];
         end
         if (hit_vec[i]) begin
            hit_handle = cell_handle[i];
            hit_rem    = cell_rem[i];
            hit_slot   = PTR_BITS'(i);
         end
      end
      any_hit = |hit_vec;
   end

   // ---- controller ----
   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      full_in      = full_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      busy         = (state_ff == rrol_pkg::ST_WALK);

      unique case (state_ff)
         rrol_pkg::ST_IDLE: begin
            if (do_add) begin
               total_in  = total_ff - (full_ff ? TOT_BITS'(old_len) : '0)
                           + TOT_BITS'(new_len);
               wr_pos_in = wr_pos_next;
               if (full_ff) begin
                  rd_pos_in = wr_pos_next;
               end
               full_in = full_ff || (wr_pos_next == rd_pos_ff);
               rsp_valid_in          = 1'b1;
               rsp_in.evicted_valid  = full_ff;
               rsp_in.evicted_handle = full_ff ? old_handle : '0;
               rsp_in.bytes_held     = total_in[rrol_pkg::HELD_BITS-1:0];
            end else if (do_find) begin
               if (in_range) begin
                  state_in = rrol_pkg::ST_WALK;
               end else begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.bytes_held = total_ff[rrol_pkg::HELD_BITS-1:0];
               end
            end
         end
         rrol_pkg::ST_WALK: begin
            if (any_hit) begin
               state_in             = rrol_pkg::ST_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_in.found         = 1'b1;
               rsp_in.slot_index    = rrol_pkg::SLOT_BITS'(hit_slot);
               rsp_in.found_handle  = hit_handle;
               rsp_in.byte_in_entry = rrol_pkg::SIZE_BITS'(hit_rem);
               rsp_in.bytes_held    = total_ff[rrol_pkg::HELD_BITS-1:0];
            end
         end
         default: begin
            state_in = rrol_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrol_pkg::ST_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         full_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         full_ff      <= full_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---- assertions ----
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell hit");

   a_one_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(probe_vec))
      else $error("more than one probe in flight");

   a_no_rsp_while_walk: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe during walk");

   a_transfer_answers: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid || busy))
      else $error("transfer produced neither result nor walk");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (wr_pos_ff == rd_pos_ff))
      else $error("full ring with unequal pointers");

endmodule
